>>> rtl/dxt_texel_decoder_unit_assert.svh
// Assertion macros used by the texel decoder checker.
`ifndef DXT_TEXEL_DECODER_UNIT_ASSERT_SVH
`define DXT_TEXEL_DECODER_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define DXT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset.
`define DXT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dxt_pkg.sv
// Package with format codes and inter-stage word types of the texel decoder.
package dxt_pkg;

  localparam logic [2:0] FMT_DXT1     = 3'd0;
  localparam logic [2:0] FMT_DXT3     = 3'd1;
  localparam logic [2:0] FMT_DXT5     = 3'd2;
  localparam logic [2:0] FMT_R5G6B5   = 3'd3;
  localparam logic [2:0] FMT_A8R8G8B8 = 3'd4;

  localparam logic [1:0] CIDX_C0  = 2'd0;
  localparam logic [1:0] CIDX_C1  = 2'd1;
  localparam logic [1:0] CIDX_MIX = 2'd2;
  localparam logic [1:0] CIDX_ALT = 2'd3;

  // Unpacked block fields after the first stage.
  typedef struct packed {
    logic [2:0]  fmt;
    logic [1:0]  cidx;
    logic        punch;
    logic [23:0] c0;
    logic [23:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [2:0]  acode;
    logic [3:0]  anib;
    logic [31:0] raw;
  } s1_t;

  // Interpolation numerators after the second stage.
  typedef struct packed {
    logic [2:0]       fmt;
    logic [1:0]       cidx;
    logic             punch;
    logic [23:0]      c0;
    logic [23:0]      c1;
    logic [2:0][9:0]  num3;
    logic [2:0][7:0]  half;
    logic [10:0]      anum;
    logic             agt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [2:0]       acode;
    logic [3:0]       anib;
    logic [31:0]      raw;
  } s2_t;

endpackage

>>> rtl/dxt_unpack.sv
// First stage: picks the color block, expands endpoints and extracts indices.
module dxt_unpack
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  fmt,
  input  logic        up_valid,
  input  logic [63:0] block_lo,
  input  logic [63:0] block_hi,
  input  logic [1:0]  texel_x,
  input  logic [1:0]  texel_y,
  output logic        up_stall,
  input  logic        dn_stall,
  output logic        dn_valid,
  output s1_t         dn_data
);

  function automatic logic [23:0] expand565(input logic [15:0] c);
    expand565 = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
  endfunction

  logic        valid_r, valid_nxt;
  s1_t         data_r, data_nxt;
  logic        advance;
  logic [63:0] cblk;
  logic [31:0] idx_word;
  logic [4:0]  coff;
  logic [5:0]  aoff;
  logic [5:0]  noff;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  always_comb begin
    cblk     = (fmt inside {FMT_DXT3, FMT_DXT5}) ? block_hi : block_lo;
    idx_word = cblk[63:32];
    coff     = {texel_y, texel_x, 1'b0};
    aoff     = 6'd16 + 6'(texel_y) * 6'd12 + 6'(texel_x) * 6'd3;
    noff     = {texel_y, texel_x, 2'b00};

    data_nxt.fmt   = fmt;
    data_nxt.cidx  = idx_word[coff +: 2];
    data_nxt.punch = !(cblk[15:0] > cblk[31:16]);
    data_nxt.c0    = expand565(cblk[15:0]);
    data_nxt.c1    = expand565(cblk[31:16]);
    data_nxt.a0    = block_lo[7:0];
    data_nxt.a1    = block_lo[15:8];
    data_nxt.acode = block_lo[aoff +: 3];
    data_nxt.anib  = block_lo[noff +: 4];
    data_nxt.raw   = block_lo[31:0];

    valid_nxt = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/dxt_interp.sv
// Second stage: forms the color and alpha interpolation numerators.
module dxt_interp
  import dxt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  s1_t  up_data,
  output logic up_stall,
  input  logic dn_stall,
  output logic dn_valid,
  output s2_t  dn_data
);

  logic        valid_r, valid_nxt;
  s2_t         data_r, data_nxt;
  logic        advance;
  logic [23:0] p, q;
  logic [3:0]  wa, wb;
  logic [11:0] pa, pb;
  logic        agt;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  always_comb begin
    // The second mixed color weights c1 double, so swap the operands.
    p = (up_data.cidx == CIDX_ALT) ? up_data.c1 : up_data.c0;
    q = (up_data.cidx == CIDX_ALT) ? up_data.c0 : up_data.c1;

    agt = up_data.a0 > up_data.a1;
    wa  = agt ? (4'd8 - {1'b0, up_data.acode}) : (4'd6 - {1'b0, up_data.acode});
    wb  = {1'b0, up_data.acode} - 4'd1;
    pa  = 12'(wa) * 12'(up_data.a0);
    pb  = 12'(wb) * 12'(up_data.a1);

    data_nxt.fmt   = up_data.fmt;
    data_nxt.cidx  = up_data.cidx;
    data_nxt.punch = up_data.punch;
    data_nxt.c0    = up_data.c0;
    data_nxt.c1    = up_data.c1;
    for (int i = 0; i < 3; i++) begin
      data_nxt.num3[i] = {1'b0, p[8*i +: 8], 1'b0} + {2'b00, q[8*i +: 8]} + 10'd1;
      data_nxt.half[i] = 8'(({1'b0, up_data.c0[8*i +: 8]} +
                             {1'b0, up_data.c1[8*i +: 8]}) >> 1);
    end
    data_nxt.anum  = 11'(pa + pb + (agt ? 12'd3 : 12'd2));
    data_nxt.agt   = agt;
    data_nxt.a0    = up_data.a0;
    data_nxt.a1    = up_data.a1;
    data_nxt.acode = up_data.acode;
    data_nxt.anib  = up_data.anib;
    data_nxt.raw   = up_data.raw;

    valid_nxt = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/dxt_resolve.sv
// Third stage: divides by constants, selects the texel and holds the output word.
module dxt_resolve
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  input  s2_t         up_data,
  output logic        up_stall,
  input  logic        dn_stall,
  output logic        dn_valid,
  output logic [31:0] dn_argb
);

  logic        valid_r, valid_nxt;
  logic [31:0] argb_r, argb_nxt;
  logic        advance;
  logic [19:0] prod3 [3];
  logic [23:0] mix3;
  logic [23:0] color4;
  logic [23:0] color3;
  logic [22:0] prod7, prod5;
  logic [7:0]  alpha5;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  always_comb begin
    // Division by 3, 7 and 5 through reciprocal multiplies; exact over the numerator range.
    for (int i = 0; i < 3; i++) begin
      prod3[i]        = 20'(up_data.num3[i]) * 20'd683;
      mix3[8*i +: 8]  = prod3[i][18:11];
    end
    prod7 = 23'(up_data.anum) * 23'd2341;
    prod5 = 23'(up_data.anum) * 23'd3277;

    case (up_data.cidx)
      CIDX_C0: color4 = up_data.c0;
      CIDX_C1: color4 = up_data.c1;
      default: color4 = mix3;
    endcase

    case (up_data.cidx)
      CIDX_C0:  color3 = up_data.c0;
      CIDX_C1:  color3 = up_data.c1;
      CIDX_MIX: color3 = up_data.half;
      default:  color3 = 24'h000000;
    endcase

    if (up_data.acode == 3'd0) begin
      alpha5 = up_data.a0;
    end else if (up_data.acode == 3'd1) begin
      alpha5 = up_data.a1;
    end else if (up_data.agt) begin
      alpha5 = prod7[21:14];
    end else if (up_data.acode == 3'd6) begin
      alpha5 = 8'd0;
    end else if (up_data.acode == 3'd7) begin
      alpha5 = 8'd255;
    end else begin
      alpha5 = prod5[21:14];
    end

    case (up_data.fmt)
      FMT_DXT1: begin
        // Transparent black for the fourth code of a three-color block.
        if (up_data.punch && (up_data.cidx == CIDX_ALT)) begin
          argb_nxt = 32'h0;
        end else if (up_data.punch) begin
          argb_nxt = {8'hff, color3};
        end else begin
          argb_nxt = {8'hff, color4};
        end
      end
      FMT_DXT3:     argb_nxt = {up_data.anib, up_data.anib, color4};
      FMT_DXT5:     argb_nxt = {alpha5, color4};
      FMT_R5G6B5:   argb_nxt = {8'h00, up_data.c0};
      FMT_A8R8G8B8: argb_nxt = up_data.raw;
      default:      argb_nxt = 32'h0;
    endcase

    valid_nxt = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      argb_r <= argb_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_argb  = argb_r;

endmodule

>>> rtl/dxt_texel_decoder_unit.sv
// Top level of the compressed texel decoder: format register and three-stage pipeline.
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall   in_block_lo, in_block_hi, in_texel_x, in_texel_y
//   out_*        output     out_valid/out_stall out_argb
//   cfg_*        input      cfg_wr_en           cfg_wr_data (texture format)
//
// One word is accepted per clock when the output side does not stall.
// A word's result passes the unpack, interpolate and resolve registers in that order
// before it shows on out_valid.
// A stall fills empty stages first; in_stall rises only when all three stages hold words.
// Reset empties the pipeline and sets the format to DXT1.
module dxt_texel_decoder_unit
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  input  logic [1:0]  in_texel_x,
  input  logic [1:0]  in_texel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_argb
);

  logic [2:0] format_r, format_nxt;
  logic       s1_valid, s2_valid;
  logic       s1_stall, s2_stall;
  s1_t        s1_data;
  s2_t        s2_data;

  assign format_nxt = cfg_wr_en ? cfg_wr_data : format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_DXT1;
    end else begin
      format_r <= format_nxt;
    end
  end

  dxt_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (format_r),
    .up_valid (in_valid),
    .block_lo (in_block_lo),
    .block_hi (in_block_hi),
    .texel_x  (in_texel_x),
    .texel_y  (in_texel_y),
    .up_stall (in_stall),
    .dn_stall (s1_stall),
    .dn_valid (s1_valid),
    .dn_data  (s1_data)
  );

  dxt_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_data  (s1_data),
    .up_stall (s1_stall),
    .dn_stall (s2_stall),
    .dn_valid (s2_valid),
    .dn_data  (s2_data)
  );

  dxt_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_data  (s2_data),
    .up_stall (s2_stall),
    .dn_stall (out_stall),
    .dn_valid (out_valid),
    .dn_argb  (out_argb)
  );

endmodule

>>> rtl/dxt_checker.sv
// Port-level checker for the texel decoder and its bind to the top level.
`include "dxt_texel_decoder_unit_assert.svh"

module dxt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_argb
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_argb);
  endproperty

  property p_stall_source;
    in_stall |-> out_valid && out_stall;
  endproperty

  property p_latency;
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid;
  endproperty

  // A held output word keeps its value until it is taken.
  `DXT_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "output word changed while stalled")

  // The pipeline is empty in the cycle after reset.
  `DXT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

  // Back pressure on the input only comes from a full, stalled output.
  `DXT_ASSERT(a_stall_source, clk, rst_n, p_stall_source, "input stalled without output stall")

  // With out_stall low, an accepted word leaves via the unpack, interpolate and resolve registers.
  `DXT_ASSERT(a_latency, clk, rst_n, p_latency, "accepted word did not reach the output")

endmodule

bind dxt_texel_decoder_unit dxt_checker u_dxt_checker (.*);
